// ----- rtl/ptc_pkg.sv -----
package ptc_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_COEFFS      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRES_COEFFS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRES_COEFFS_HIGH = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRES_COEFF_NINE  = 2'd3;

   localparam int FRONT_STAGES = 11;
   localparam int DIV_BITS     = 64;
   localparam int TAIL_STAGES  = 6;
   localparam int BACK_STAGES  = DIV_BITS + 1 + TAIL_STAGES;
   localparam int DEN_W        = 31;

   localparam logic [31:0] TEMP_ROUND  = 32'd128;
   localparam logic [33:0] FINE_OFFSET = 34'd128000;
   localparam logic [20:0] PRES_BASE   = 21'd1048576;
   localparam logic [11:0] PRES_SCALE  = 12'd3125;
   localparam logic [63:0] PRES_BIAS   = 64'h0000_8000_0000_0000;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } ptc_coeff_type;

   typedef struct packed {
      logic             zero;
      logic [31:0]      temp_centi;
      logic [31:0]      fine;
   } ptc_side_type;

   typedef struct packed {
      logic [63:0]      num_mag;
      logic [DEN_W-1:0] den_mag;
      logic             neg;
      ptc_side_type     side;
   } ptc_item_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [63:0]      nq;
      logic [DEN_W-1:0] den;
      logic             neg;
      ptc_side_type     side;
   } ptc_div_type;

endpackage

// ----- rtl/ptc_channels.sv -----
interface ptc_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_temperature;
   logic [19:0] raw_pressure;

   modport source(output valid, output raw_temperature, output raw_pressure, input ready);
   modport sink(input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface ptc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] temp_centi_deg;
   logic signed [31:0] fine_temp;
   logic [31:0]        pressure_q24_8;
   logic [23:0]        pressure_pa;
   logic               divisor_zero;

   modport source(output valid, output temp_centi_deg, output fine_temp,
                  output pressure_q24_8, output pressure_pa, output divisor_zero,
                  input ready);
   modport sink(input valid, input temp_centi_deg, input fine_temp,
                input pressure_q24_8, input pressure_pa, input divisor_zero,
                output ready);
endinterface

// ----- rtl/ptc_front.sv -----
module ptc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  ptc_pkg::ptc_coeff_type coeff,
   ptc_req_if.sink                req,
   output logic                   push_valid,
   output ptc_pkg::ptc_item_type  push_item,
   input  logic                   push_ready
);
   import ptc_pkg::*;

   logic [FRONT_STAGES-1:0] valid_ff, valid_in;
   logic                    advance;

   logic signed [15:0] p2_s, p3_s, p5_s, p6_s;
   logic [31:0] t1x, t1x2, t2x, t3x, p3x, p6x;
   logic [31:0] x_w, d_w, rt_sh3, rt_sh4;

   // temperature stages
   logic [31:0] s1_aprod_ff, s1_aprod_in, s1_dd_ff, s1_dd_in;
   logic [31:0] s2_a_ff, s2_a_in, s2_bprod_ff, s2_bprod_in;
   logic [31:0] dd_sh;
   logic [31:0] s3_fine_ff, s3_fine_in, b_sh;
   logic [31:0] tmp5;
   logic [31:0] s4_tc_ff, s4_tc_in;
   logic signed [33:0] s4_v1_ff, s4_v1_in;
   logic [19:0] rp1_ff, rp2_ff, rp3_ff, rp4_ff, rp5_ff, rp6_ff;

   // pressure stages
   logic signed [67:0] sq_full;
   logic [63:0] s5_sq_ff, s5_sq_in;
   logic signed [49:0] s5_m5_ff, s5_m5_in, s5_m2_ff, s5_m2_in;
   logic signed [48:0] s6_alo_ff, s6_alo_in, s6_clo_ff, s6_clo_in;
   logic [31:0] s6_ahi_ff, s6_ahi_in, s6_chi_ff, s6_chi_in;
   logic signed [49:0] s6_m5_ff, s6_m2_ff;
   logic [63:0] csum;
   logic [63:0] s7_v2_ff, s7_v2_in, s7_v1b_ff, s7_v1b_in;
   logic [20:0] s7_p_ff, s7_p_in;
   logic [63:0] s_w;
   logic [63:0] s8_diff_ff, s8_diff_in;
   logic [47:0] s8_slo_ff, s8_slo_in;
   logic [31:0] s8_shi_ff, s8_shi_in;
   logic [63:0] den_full;
   logic [DEN_W-1:0] s9_den_ff, s9_den_in;
   logic [43:0] s9_nlo_ff, s9_nlo_in;
   logic [31:0] s9_nhi_ff, s9_nhi_in;
   logic [63:0] s10_num_ff, s10_num_in;
   logic [DEN_W-1:0] s10_den_ff, s10_den_in;
   logic s10_neg_ff, s10_neg_in, s10_zero_ff, s10_zero_in;
   ptc_item_type s11_ff, s11_in;

   logic [31:0] tc5_ff, tc6_ff, tc7_ff, tc8_ff, tc9_ff, tc10_ff;
   logic [31:0] f4_ff, f5_ff, f6_ff, f7_ff, f8_ff, f9_ff, f10_ff;

   assign advance    = !valid_ff[FRONT_STAGES-1] || push_ready;
   assign req.ready  = advance;
   assign push_valid = valid_ff[FRONT_STAGES-1];
   assign push_item  = s11_ff;
   assign valid_in   = {valid_ff[FRONT_STAGES-2:0], req.valid};

   assign p2_s = coeff.p2;
   assign p3_s = coeff.p3;
   assign p5_s = coeff.p5;
   assign p6_s = coeff.p6;
   assign t1x  = {16'b0, coeff.t1};
   assign t1x2 = {15'b0, coeff.t1, 1'b0};
   assign t2x  = {{16{coeff.t2[15]}}, coeff.t2};
   assign t3x  = {{16{coeff.t3[15]}}, coeff.t3};
   assign p3x  = {{16{coeff.p3[15]}}, coeff.p3};
   assign p6x  = {{16{coeff.p6[15]}}, coeff.p6};

   always_comb begin
      rt_sh3      = {15'b0, req.raw_temperature[19:3]};
      rt_sh4      = {16'b0, req.raw_temperature[19:4]};
      x_w         = rt_sh3 - t1x2;
      d_w         = rt_sh4 - t1x;
      s1_aprod_in = x_w * t2x;
      s1_dd_in    = d_w * d_w;

      s2_a_in     = $signed(s1_aprod_ff) >>> 11;
      dd_sh       = $signed(s1_dd_ff) >>> 12;
      s2_bprod_in = dd_sh * t3x;

      b_sh        = $signed(s2_bprod_ff) >>> 14;
      s3_fine_in  = s2_a_ff + b_sh;

      tmp5        = {s3_fine_ff[29:0], 2'b0} + s3_fine_ff + TEMP_ROUND;
      s4_tc_in    = $signed(tmp5) >>> 8;
      s4_v1_in    = {{2{s3_fine_ff[31]}}, s3_fine_ff} - FINE_OFFSET;

      sq_full     = s4_v1_ff * s4_v1_ff;
      s5_sq_in    = sq_full[63:0];
      s5_m5_in    = s4_v1_ff * p5_s;
      s5_m2_in    = s4_v1_ff * p2_s;

      s6_alo_in   = $signed({1'b0, s5_sq_ff[31:0]}) * p6_s;
      s6_ahi_in   = s5_sq_ff[63:32] * p6x;
      s6_clo_in   = $signed({1'b0, s5_sq_ff[31:0]}) * p3_s;
      s6_chi_in   = s5_sq_ff[63:32] * p3x;

      s7_v2_in    = {{15{s6_alo_ff[48]}}, s6_alo_ff} + {s6_ahi_ff, 32'b0}
                  + ({{14{s6_m5_ff[49]}}, s6_m5_ff} << 17)
                  + ({{48{coeff.p4[15]}}, coeff.p4} << 35);
      csum        = {{15{s6_clo_ff[48]}}, s6_clo_ff} + {s6_chi_ff, 32'b0};
      s7_v1b_in   = ($signed(csum) >>> 8)
                  + $signed({{14{s6_m2_ff[49]}}, s6_m2_ff} << 12);
      s7_p_in     = PRES_BASE - {1'b0, rp6_ff};

      s8_diff_in  = {12'b0, s7_p_ff, 31'b0} - s7_v2_ff;
      s_w         = s7_v1b_ff + PRES_BIAS;
      s8_slo_in   = s_w[31:0] * coeff.p1;
      s8_shi_in   = s_w[63:32] * {16'b0, coeff.p1};

      den_full    = {16'b0, s8_slo_ff} + {s8_shi_ff, 32'b0};
      s9_den_in   = den_full[63:33];
      s9_nlo_in   = s8_diff_ff[31:0] * PRES_SCALE;
      s9_nhi_in   = s8_diff_ff[63:32] * {20'b0, PRES_SCALE};

      s10_num_in  = {20'b0, s9_nlo_ff} + {s9_nhi_ff, 32'b0};
      s10_den_in  = s9_den_ff[DEN_W-1] ? (~s9_den_ff + 1'b1) : s9_den_ff;
      s10_neg_in  = s10_num_in[63] ^ s9_den_ff[DEN_W-1];
      s10_zero_in = (s9_den_ff == '0);

      s11_in.num_mag         = s10_num_ff[63] ? (~s10_num_ff + 64'd1) : s10_num_ff;
      s11_in.den_mag         = s10_den_ff;
      s11_in.neg             = s10_neg_ff;
      s11_in.side.zero       = s10_zero_ff;
      s11_in.side.temp_centi = tc10_ff;
      s11_in.side.fine       = f10_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_aprod_ff <= s1_aprod_in;
         s1_dd_ff    <= s1_dd_in;
         rp1_ff      <= req.raw_pressure;
         s2_a_ff     <= s2_a_in;
         s2_bprod_ff <= s2_bprod_in;
         rp2_ff      <= rp1_ff;
         s3_fine_ff  <= s3_fine_in;
         rp3_ff      <= rp2_ff;
         s4_tc_ff    <= s4_tc_in;
         s4_v1_ff    <= s4_v1_in;
         f4_ff       <= s3_fine_ff;
         rp4_ff      <= rp3_ff;
         s5_sq_ff    <= s5_sq_in;
         s5_m5_ff    <= s5_m5_in;
         s5_m2_ff    <= s5_m2_in;
         tc5_ff      <= s4_tc_ff;
         f5_ff       <= f4_ff;
         rp5_ff      <= rp4_ff;
         s6_alo_ff   <= s6_alo_in;
         s6_ahi_ff   <= s6_ahi_in;
         s6_clo_ff   <= s6_clo_in;
         s6_chi_ff   <= s6_chi_in;
         s6_m5_ff    <= s5_m5_ff;
         s6_m2_ff    <= s5_m2_ff;
         tc6_ff      <= tc5_ff;
         f6_ff       <= f5_ff;
         rp6_ff      <= rp5_ff;
         s7_v2_ff    <= s7_v2_in;
         s7_v1b_ff   <= s7_v1b_in;
         s7_p_ff     <= s7_p_in;
         tc7_ff      <= tc6_ff;
         f7_ff       <= f6_ff;
         s8_diff_ff  <= s8_diff_in;
         s8_slo_ff   <= s8_slo_in;
         s8_shi_ff   <= s8_shi_in;
         tc8_ff      <= tc7_ff;
         f8_ff       <= f7_ff;
         s9_den_ff   <= s9_den_in;
         s9_nlo_ff   <= s9_nlo_in;
         s9_nhi_ff   <= s9_nhi_in;
         tc9_ff      <= tc8_ff;
         f9_ff       <= f8_ff;
         s10_num_ff  <= s10_num_in;
         s10_den_ff  <= s10_den_in;
         s10_neg_ff  <= s10_neg_in;
         s10_zero_ff <= s10_zero_in;
         tc10_ff     <= tc9_ff;
         f10_ff      <= f9_ff;
         s11_ff      <= s11_in;
      end
   end

endmodule

// ----- rtl/ptc_queue.sv -----
module ptc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  ptc_pkg::ptc_item_type push_item,
   output logic                  push_ready,
   output logic                  pop_valid,
   output ptc_pkg::ptc_item_type pop_item,
   input  logic                  pop_ready
);
   import ptc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   ptc_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/ptc_back.sv -----
module ptc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ptc_pkg::ptc_coeff_type coeff,
   input  logic                   pop_valid,
   input  ptc_pkg::ptc_item_type  pop_item,
   output logic                   pop_ready,
   ptc_rsp_if.source              rsp
);
   import ptc_pkg::*;

   logic [BACK_STAGES-1:0] valid_ff, valid_in;
   logic                   advance;

   ptc_div_type div_ff [DIV_BITS+1];
   ptc_div_type div_in [DIV_BITS+1];

   logic signed [15:0] p8_s, p9_s;
   logic [31:0] p8x, p9x;

   logic [63:0] b0_q_ff, b0_q_in;
   ptc_side_type b0_side_ff, b1_side_ff, b2_side_ff, b3_side_ff, b4_side_ff, b5_side_ff;
   logic [63:0] x_w;
   logic [63:0] b1_xx_ff, b1_xx_in, b1_q_ff;
   logic [31:0] b1_xlh_ff, b1_xlh_in, b1_ph_ff, b1_ph_in;
   logic signed [48:0] b1_pl_ff, b1_pl_in;
   logic [63:0] lo_sum;
   logic [63:0] b2_sq_ff, b2_sq_in, b2_lo_ff, b2_lo_in, b2_q_ff;
   logic signed [48:0] b3_hl_ff, b3_hl_in;
   logic [31:0] b3_hh_ff, b3_hh_in;
   logic [63:0] b3_lo_ff, b3_q_ff;
   logic [63:0] hi_sum;
   logic [63:0] b4_hi_ff, b4_hi_in, b4_sum_ff, b4_sum_in;
   logic [63:0] fin_sum, res_w;
   logic [31:0] b5_pres_ff, b5_pres_in;

   assign advance   = !valid_ff[BACK_STAGES-1] || rsp.ready;
   assign pop_ready = advance;
   assign valid_in  = {valid_ff[BACK_STAGES-2:0], pop_valid};

   assign p8_s = coeff.p8;
   assign p9_s = coeff.p9;
   assign p8x  = {{16{coeff.p8[15]}}, coeff.p8};
   assign p9x  = {{16{coeff.p9[15]}}, coeff.p9};

   always_comb begin
      div_in[0].rem  = '0;
      div_in[0].nq   = pop_item.num_mag;
      div_in[0].den  = pop_item.den_mag;
      div_in[0].neg  = pop_item.neg;
      div_in[0].side = pop_item.side;
   end

   for (genvar i = 1; i <= DIV_BITS; i++) begin : g_div
      logic [DEN_W-1:0] shifted;
      logic             fits;
      always_comb begin
         shifted        = {div_ff[i-1].rem[DEN_W-2:0], div_ff[i-1].nq[63]};
         fits           = (shifted >= div_ff[i-1].den);
         div_in[i]      = div_ff[i-1];
         div_in[i].rem  = fits ? (shifted - div_ff[i-1].den) : shifted;
         div_in[i].nq   = {div_ff[i-1].nq[62:0], fits};
      end
   end

   always_comb begin
      b0_q_in   = div_ff[DIV_BITS].neg ? (~div_ff[DIV_BITS].nq + 64'd1)
                                       : div_ff[DIV_BITS].nq;

      x_w       = $signed(b0_q_ff) >>> 13;
      b1_xx_in  = x_w[31:0] * x_w[31:0];
      b1_xlh_in = x_w[31:0] * x_w[63:32];
      b1_pl_in  = $signed({1'b0, b0_q_ff[31:0]}) * p8_s;
      b1_ph_in  = b0_q_ff[63:32] * p8x;

      b2_sq_in  = b1_xx_ff + {b1_xlh_ff[30:0], 33'b0};
      lo_sum    = {{15{b1_pl_ff[48]}}, b1_pl_ff} + {b1_ph_ff, 32'b0};
      b2_lo_in  = $signed(lo_sum) >>> 19;

      b3_hl_in  = $signed({1'b0, b2_sq_ff[31:0]}) * p9_s;
      b3_hh_in  = b2_sq_ff[63:32] * p9x;

      hi_sum    = {{15{b3_hl_ff[48]}}, b3_hl_ff} + {b3_hh_ff, 32'b0};
      b4_hi_in  = $signed(hi_sum) >>> 25;
      b4_sum_in = b3_q_ff + b3_lo_ff;

      fin_sum   = b4_sum_ff + b4_hi_ff;
      res_w     = ($signed(fin_sum) >>> 8)
                + $signed({{48{coeff.p7[15]}}, coeff.p7} << 4);
      b5_pres_in = b4_side_ff.zero ? 32'd0 : res_w[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i <= DIV_BITS; i++) begin
            div_ff[i] <= div_in[i];
         end
         b0_q_ff    <= b0_q_in;
         b0_side_ff <= div_ff[DIV_BITS].side;
         b1_xx_ff   <= b1_xx_in;
         b1_xlh_ff  <= b1_xlh_in;
         b1_pl_ff   <= b1_pl_in;
         b1_ph_ff   <= b1_ph_in;
         b1_q_ff    <= b0_q_ff;
         b1_side_ff <= b0_side_ff;
         b2_sq_ff   <= b2_sq_in;
         b2_lo_ff   <= b2_lo_in;
         b2_q_ff    <= b1_q_ff;
         b2_side_ff <= b1_side_ff;
         b3_hl_ff   <= b3_hl_in;
         b3_hh_ff   <= b3_hh_in;
         b3_lo_ff   <= b2_lo_ff;
         b3_q_ff    <= b2_q_ff;
         b3_side_ff <= b2_side_ff;
         b4_hi_ff   <= b4_hi_in;
         b4_sum_ff  <= b4_sum_in;
         b4_side_ff <= b3_side_ff;
         b5_pres_ff <= b5_pres_in;
         b5_side_ff <= b4_side_ff;
      end
   end

   assign rsp.valid          = valid_ff[BACK_STAGES-1];
   assign rsp.temp_centi_deg = b5_side_ff.temp_centi;
   assign rsp.fine_temp      = b5_side_ff.fine;
   assign rsp.pressure_q24_8 = b5_pres_ff;
   assign rsp.pressure_pa    = b5_pres_ff[31:8];
   assign rsp.divisor_zero   = b5_side_ff.zero;

endmodule

// ----- rtl/pressure_temperature_compensation.sv -----
// Pipeline: 11 front stages, the queue, 65 divider stages and 6 tail stages.
// Throughput: one request per cycle while the response channel is not stalled, set by
//    the one-bit-per-stage pipelined divider and the fully pipelined multiplier
//    stages.
// Reset: synchronous; clears pipeline valid bits, queue pointers and coefficients.
module pressure_temperature_compensation #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   ptc_req_if.sink                         req_channel,
   ptc_rsp_if.source                       rsp_channel,
   input  logic                            csr_write_enable,
   input  logic [ptc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ptc_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import ptc_pkg::*;

   logic [47:0] temp_coeffs_ff;
   logic [63:0] pres_low_ff, pres_high_ff;
   logic [15:0] pres_nine_ff;
   ptc_coeff_type coeff;

   logic         push_valid, push_ready, pop_valid, pop_ready;
   ptc_item_type push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         pres_low_ff    <= '0;
         pres_high_ff   <= '0;
         pres_nine_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TEMP_COEFFS:      temp_coeffs_ff <= csr_write_data[47:0];
            CSR_PRES_COEFFS_LOW:  pres_low_ff    <= csr_write_data;
            CSR_PRES_COEFFS_HIGH: pres_high_ff   <= csr_write_data;
            CSR_PRES_COEFF_NINE:  pres_nine_ff   <= csr_write_data[15:0];
            default:              pres_nine_ff   <= pres_nine_ff;
         endcase
      end
   end

   always_comb begin
      coeff.t1 = temp_coeffs_ff[15:0];
      coeff.t2 = temp_coeffs_ff[31:16];
      coeff.t3 = temp_coeffs_ff[47:32];
      coeff.p1 = pres_low_ff[15:0];
      coeff.p2 = pres_low_ff[31:16];
      coeff.p3 = pres_low_ff[47:32];
      coeff.p4 = pres_low_ff[63:48];
      coeff.p5 = pres_high_ff[15:0];
      coeff.p6 = pres_high_ff[31:16];
      coeff.p7 = pres_high_ff[47:32];
      coeff.p8 = pres_high_ff[63:48];
      coeff.p9 = pres_nine_ff;
   end

   ptc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .coeff      (coeff),
      .req        (req_channel),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   ptc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   ptc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .coeff     (coeff),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_ready (pop_ready),
      .rsp       (rsp_channel)
   );

endmodule

// ----- rtl/ptc_checker.sv -----
module ptc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] pressure_q24_8,
   input logic [23:0] pressure_pa,
   input logic        divisor_zero
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pressure_q24_8))
      else $error("stalled response dropped or changed");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && divisor_zero |-> pressure_q24_8 == 32'd0)
      else $error("pressure not cleared on zero divisor");

   a_pa: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pressure_pa == pressure_q24_8[31:8])
      else $error("integer pressure does not match fixed-point pressure");

endmodule

bind pressure_temperature_compensation ptc_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_channel.valid),
   .rsp_ready      (rsp_channel.ready),
   .pressure_q24_8 (rsp_channel.pressure_q24_8),
   .pressure_pa    (rsp_channel.pressure_pa),
   .divisor_zero   (rsp_channel.divisor_zero)
);
